// ----- hdl/mrw_pkg.sv -----
// Package with shared widths, types and sequencer state codes for the witness round.
package mrw_pkg;
  localparam int WordBits = 63;
  localparam int RandBits = 32;
  localparam int CntBits = $clog2(WordBits + 1);
  localparam int IdxBits = $clog2(WordBits);

  typedef logic [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic [IdxBits-1:0] idx_t;

  // Shared unit operations.
  typedef enum logic [1:0] {
    OP_MULMOD = 2'd0,
    OP_REM    = 2'd1
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FACTOR = 8'b0000_0010,
    ST_REM    = 8'b0000_0100,
    ST_PMUL   = 8'b0000_1000,
    ST_PSQR   = 8'b0001_0000,
    ST_CHECK  = 8'b0010_0000,
    ST_SQR    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;
endpackage

// ----- hdl/mrw_stream_if.sv -----
// Valid/ready channel interface carrying a parameterized payload type.
interface mrw_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/miller_rabin_witness_round.sv -----
// Top level of the single-round Miller-Rabin witness test.
// One beat in gives one beat out: probably_prime for the 63-bit candidate with the
// base (random_word mod (candidate-2)) + 2. Candidates below 2 answer 0, and 2 and 3
// answer 1, with the result beat offered in the cycle right after the input beat is
// taken. For others the block removes one trailing zero of candidate-1 per cycle,
// then runs every modular operation (the base remainder, each multiply and square
// of the power, and each later square) on one shared bit-serial unit that runs
// 63 steps per operation, between the issue and the hand-back of the result.
// The input is not ready while a round is in progress or its result beat waits
// to be taken.
module miller_rabin_witness_round
  import mrw_pkg::*;
(
  input logic clk,
  input logic rst,
  mrw_stream_if.sink   in_ch,
  mrw_stream_if.source out_ch
);
  unit_cmd_t  cmd;
  unit_stat_t stat;
  word_t      ua;
  word_t      ub;
  word_t      um;
  word_t      ures;
  logic       idle;

  // The input bus is a struct with candidate and random_word.
  assign in_ch.ready = idle;

  mrw_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_ch.valid && idle),
    .cand_in  (in_ch.data.candidate),
    .rand_in  (word_t'(in_ch.data.random_word)),
    .idle     (idle),
    .res_valid(out_ch.valid),
    .res_ready(out_ch.ready),
    .verdict  (out_ch.data.probably_prime),
    .cmd      (cmd),
    .ua       (ua),
    .ub       (ub),
    .um       (um),
    .stat     (stat),
    .ures     (ures)
  );

  mrw_modunit u_unit (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .a     (ua),
    .b     (ub),
    .m     (um),
    .stat  (stat),
    .result(ures)
  );
endmodule

// ----- hdl/mrw_modunit.sv -----
// Shared bit-serial unit: modular multiply by shift-and-add, or remainder by restoring steps.
module mrw_modunit
  import mrw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  unit_cmd_t  cmd,
  input  word_t      a,
  input  word_t      b,
  input  word_t      m,
  output unit_stat_t stat,
  output word_t      result
);
  logic  busy;
  logic  done;
  op_t   op;
  idx_t  bit_idx;
  word_t acc;
  word_t opa;
  word_t opb;
  word_t modv;

  logic [WordBits:0] dbl;
  logic [WordBits:0] dbl_red;
  logic [WordBits:0] sum;
  word_t             step;

  always_comb begin
    if (op == OP_MULMOD) begin
      dbl = {acc, 1'b0};
    end else begin
      dbl = {acc, opb[bit_idx]};
    end
    dbl_red = (dbl >= {1'b0, modv}) ? dbl - {1'b0, modv} : dbl;
    sum = dbl_red + {1'b0, opa};
    if (op == OP_MULMOD && opb[bit_idx]) begin
      step = (sum >= {1'b0, modv}) ? word_t'(sum - {1'b0, modv}) : word_t'(sum);
    end else begin
      step = word_t'(dbl_red);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bit_idx == '0);
      if (cmd.start && !busy) begin
        busy    <= 1'b1;
        op      <= cmd.op;
        opa     <= a;
        opb     <= b;
        modv    <= m;
        acc     <= '0;
        bit_idx <= idx_t'(WordBits - 1);
      end else if (busy) begin
        acc <= step;
        if (bit_idx == '0) begin
          busy <= 1'b0;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign result = acc;
endmodule

// ----- hdl/mrw_seq.sv -----
// Sequencer for one Miller-Rabin round driving the shared modular unit.
module mrw_seq
  import mrw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  word_t      cand_in,
  input  word_t      rand_in,
  output logic       idle,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       verdict,
  output unit_cmd_t  cmd,
  output word_t      ua,
  output word_t      ub,
  output word_t      um,
  input  unit_stat_t stat,
  input  word_t      ures
);
  state_t state;
  word_t  n;
  word_t  nm1;
  word_t  d;
  word_t  rnd;
  word_t  base;
  word_t  x;
  cnt_t   r;
  cnt_t   i;
  logic   issued;
  logic   pass;

  assign idle = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign verdict = pass;

  always_comb begin
    cmd.start = 1'b0;
    cmd.op = OP_MULMOD;
    ua = x;
    ub = base;
    um = n;
    unique case (state)
      ST_REM: begin
        cmd.start = !issued;
        cmd.op = OP_REM;
        ua = '0;
        ub = rnd;
        um = n - word_t'(2);
      end
      ST_PMUL: begin
        cmd.start = !issued;
        ua = x;
        ub = base;
      end
      ST_PSQR: begin
        // No square is needed once the exponent is down to its last bit.
        cmd.start = !issued && (d != word_t'(1));
        ua = base;
        ub = base;
      end
      ST_SQR: begin
        cmd.start = !issued;
        ua = x;
        ub = x;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n <= cand_in;
            nm1 <= cand_in - 1'b1;
            d <= cand_in - 1'b1;
            rnd <= rand_in;
            r <= '0;
            issued <= 1'b0;
            if (cand_in < word_t'(2)) begin
              pass <= 1'b0;
              state <= ST_OUT;
            end else if (cand_in < word_t'(4)) begin
              pass <= 1'b1;
              state <= ST_OUT;
            end else begin
              state <= ST_FACTOR;
            end
          end
        end
        ST_FACTOR: begin
          // Strip one trailing zero of n-1 per cycle.
          if (d[0]) begin
            state <= ST_REM;
          end else begin
            d <= d >> 1;
            r <= r + 1'b1;
          end
        end
        ST_REM: begin
          if (stat.done) begin
            base <= ures + word_t'(2);
            x <= word_t'(1);
            issued <= 1'b0;
            state <= d[0] ? ST_PMUL : ST_PSQR;
          end else begin
            issued <= 1'b1;
          end
        end
        ST_PMUL: begin
          if (stat.done) begin
            x <= ures;
            issued <= 1'b0;
            state <= ST_PSQR;
          end else begin
            issued <= 1'b1;
          end
        end
        ST_PSQR: begin
          if (d == word_t'(1)) begin
            state <= ST_CHECK;
            i <= cnt_t'(1);
          end else begin
            if (stat.done) begin
              base <= ures;
              d <= d >> 1;
              issued <= 1'b0;
              state <= d[1] ? ST_PMUL : ST_PSQR;
            end else begin
              issued <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (x == word_t'(1) || x == nm1) begin
            pass <= 1'b1;
            state <= ST_OUT;
          end else if (i >= r) begin
            pass <= 1'b0;
            state <= ST_OUT;
          end else begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (stat.done) begin
            issued <= 1'b0;
            x <= ures;
            i <= i + 1'b1;
            if (ures == nm1) begin
              pass <= 1'b1;
              state <= ST_OUT;
            end else if (i + 1'b1 >= r) begin
              pass <= 1'b0;
              state <= ST_OUT;
            end else begin
              state <= ST_SQR;
            end
          end else begin
            issued <= 1'b1;
          end
        end
        ST_OUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/mrw_checker.sv -----
// Port-level checker for the witness round and its bind.
module mrw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_no_result_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind miller_rabin_witness_round mrw_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready)
);
